// ----- rtl/room_allocator_free_fifo_macros.svh -----
// Assertion macros used by the RTL file room_allocator_free_fifo.sv.
`ifndef ROOM_ALLOCATOR_FREE_FIFO_MACROS_SVH
`define ROOM_ALLOCATOR_FREE_FIFO_MACROS_SVH

`ifndef ASSERT_OFF
// Concurrent check, disabled while reset is high.
`define RAFQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Concurrent check that also holds during reset.
`define RAFQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RAFQ_ASSERT(lbl, clk, rst, prop, msg)
`define RAFQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/rafq_pkg.sv -----
`timescale 1ns / 1ps
package rafq_pkg;

   localparam int CUSTOMER_SLOTS = 1024;
   localparam int MAX_ROOMS      = 256;

   localparam int CUST_W   = 10;
   localparam int CUST_AW  = $clog2(CUSTOMER_SLOTS);
   localparam int ROOM_W   = 9;
   localparam int FIFO_AW  = $clog2(MAX_ROOMS);
   localparam int STATUS_W = 2;

   typedef logic [ROOM_W-1:0]   room_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam logic CMD_ARRIVE = 1'b0;
   localparam logic CMD_DEPART = 1'b1;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_NO_ROOM = 2'd1;
   localparam status_type ST_UNKNOWN = 2'd2;

   localparam room_type ROOM_NONE      = '0;
   localparam room_type ROOM_LIMIT_RST = room_type'(256);
   localparam room_type MAX_ROOMS_R    = room_type'(MAX_ROOMS);

endpackage

// ----- rtl/rafq_if.sv -----
`timescale 1ns / 1ps
interface rafq_req_if;
   logic                       valid;
   logic                       ready;
   logic                       command;
   logic [rafq_pkg::CUST_W-1:0] customer;

   modport source (output valid, output command, output customer, input ready);
   modport sink   (input valid, input command, input customer, output ready);
endinterface

interface rafq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rafq_pkg::ROOM_W-1:0]   room;
   logic [rafq_pkg::ROOM_W-1:0]   rooms_opened;
   logic [rafq_pkg::STATUS_W-1:0] status;

   modport source (output valid, output room, output rooms_opened, output status,
                   input ready);
   modport sink   (input valid, input room, input rooms_opened, input status,
                   output ready);
endinterface

// ----- rtl/room_allocator_free_fifo.sv -----
`timescale 1ns / 1ps
`include "room_allocator_free_fifo_macros.svh"
// Greedy room allocator. Each item is an arrival (command 0) or departure
// (command 1) of a customer; arrivals keep a held room, else reuse the oldest
// freed room, else open a new room numbered from 1 up to min(room limit, 256).
// Every item yields one result with the room, the rooms opened so far and a
// status. An item reads the customer table and the free-room FIFO, then decides
// and writes both back once the output register is free; the result sits there
// while the next item is taken. After reset the customer table is cleared, one
// entry a cycle, before the first item is accepted. The room limit is to be
// written through csr_wr_en / csr_wr_data while the block is idle (not enforced).
module room_allocator_free_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [rafq_pkg::ROOM_W-1:0]   csr_wr_data,
   rafq_req_if.sink                      req_chan,
   rafq_rsp_if.source                    rsp_chan
);
   import rafq_pkg::*;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CUST_AW-1:0] clr_addr_ff, clr_addr_in;
   room_type           room_limit_ff, room_limit_in;
   logic [CUST_AW-1:0] slot_ff, slot_in;
   logic               command_ff, command_in;
   logic [FIFO_AW-1:0] free_head_ff, free_head_in;
   logic [FIFO_AW-1:0] free_tail_ff, free_tail_in;
   room_type           free_count_ff, free_count_in;
   room_type           opened_count_ff, opened_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   room_type           rsp_room_ff, rsp_room_in;
   room_type           rsp_opened_ff, rsp_opened_in;
   status_type         rsp_status_ff, rsp_status_in;

   logic               req_take;
   logic               exec_go;
   logic               tbl_we;
   logic [CUST_AW-1:0] tbl_waddr;
   room_type           tbl_wdata;
   logic [CUST_AW-1:0] tbl_raddr;
   room_type           held;
   room_type           fifo_out;
   room_type           lim;
   logic               upd_tbl, do_pop, do_push, do_open;
   room_type           upd_data;
   room_type           res_room;
   status_type         res_status;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign exec_go        = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_chan.ready);
   assign lim            = (room_limit_ff < MAX_ROOMS_R) ? room_limit_ff : MAX_ROOMS_R;

   // decide the item from the table entry and the FIFO head read last cycle
   always_comb begin
      upd_tbl    = 1'b0;
      upd_data   = ROOM_NONE;
      do_pop     = 1'b0;
      do_push    = 1'b0;
      do_open    = 1'b0;
      res_room   = ROOM_NONE;
      res_status = ST_OK;
      if (command_ff == CMD_ARRIVE) begin
         if (held != ROOM_NONE) begin
            res_room = held;
         end else if (free_count_ff != '0) begin
            do_pop   = 1'b1;
            upd_tbl  = 1'b1;
            upd_data = fifo_out;
            res_room = fifo_out;
         end else if (opened_count_ff < lim) begin
            do_open  = 1'b1;
            upd_tbl  = 1'b1;
            upd_data = opened_count_ff + 1'b1;
            res_room = opened_count_ff + 1'b1;
         end else begin
            res_status = ST_NO_ROOM;
         end
      end else begin
         if (held == ROOM_NONE) begin
            res_status = ST_UNKNOWN;
         end else begin
            do_push  = (free_count_ff < MAX_ROOMS_R);
            upd_tbl  = 1'b1;
            upd_data = ROOM_NONE;
            res_room = held;
         end
      end
   end

   always_comb begin
      state_in        = state_ff;
      clr_addr_in     = clr_addr_ff;
      room_limit_in   = csr_wr_en ? csr_wr_data : room_limit_ff;
      slot_in         = req_take ? req_chan.customer[CUST_AW-1:0] : slot_ff;
      command_in      = req_take ? req_chan.command : command_ff;
      free_head_in    = free_head_ff;
      free_tail_in    = free_tail_ff;
      free_count_in   = free_count_ff;
      opened_count_in = opened_count_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_room_in     = rsp_room_ff;
      rsp_opened_in   = rsp_opened_ff;
      rsp_status_in   = rsp_status_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == CUST_AW'(CUSTOMER_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_go) begin
               state_in = S_IDLE;
               if (do_pop) begin
                  free_head_in = free_head_ff + 1'b1;
               end
               if (do_push) begin
                  free_tail_in = free_tail_ff + 1'b1;
               end
               free_count_in   = free_count_ff + room_type'(do_push) - room_type'(do_pop);
               opened_count_in = opened_count_ff + room_type'(do_open);
               rsp_valid_in    = 1'b1;
               rsp_room_in     = res_room;
               rsp_opened_in   = opened_count_ff + room_type'(do_open);
               rsp_status_in   = res_status;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         clr_addr_ff     <= '0;
         room_limit_ff   <= ROOM_LIMIT_RST;
         free_head_ff    <= '0;
         free_tail_ff    <= '0;
         free_count_ff   <= '0;
         opened_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_addr_ff     <= clr_addr_in;
         room_limit_ff   <= room_limit_in;
         free_head_ff    <= free_head_in;
         free_tail_ff    <= free_tail_in;
         free_count_ff   <= free_count_in;
         opened_count_ff <= opened_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      command_ff    <= command_in;
      rsp_room_ff   <= rsp_room_in;
      rsp_opened_ff <= rsp_opened_in;
      rsp_status_ff <= rsp_status_in;
   end

   // table port: clearing sweep after reset, else write-back of the item
   assign tbl_we    = (state_ff == S_CLEAR) || (exec_go && upd_tbl);
   assign tbl_waddr = (state_ff == S_CLEAR) ? clr_addr_ff : slot_ff;
   assign tbl_wdata = (state_ff == S_CLEAR) ? ROOM_NONE : upd_data;
   // hold the read address through the decide cycle so the read data stays put
   assign tbl_raddr = (state_ff == S_IDLE) ? req_chan.customer[CUST_AW-1:0] : slot_ff;

   rafq_ram #(
      .Width (ROOM_W),
      .Depth (CUSTOMER_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (tbl_raddr),
      .rd_data (held)
   );

   rafq_ram #(
      .Width (ROOM_W),
      .Depth (MAX_ROOMS)
   ) u_free_fifo (
      .clock   (clock),
      .wr_en   (exec_go && do_push),
      .wr_addr (free_tail_ff),
      .wr_data (held),
      .rd_addr (free_head_ff),
      .rd_data (fifo_out)
   );

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.room         = rsp_room_ff;
   assign rsp_chan.rooms_opened = rsp_opened_ff;
   assign rsp_chan.status       = rsp_status_ff;

   `RAFQ_ASSERT(a_take_to_exec, clock, reset,
      req_take |=> (state_ff == S_EXEC), "accepted item did not enter the decide cycle")
   `RAFQ_ASSERT(a_free_le_opened, clock, reset,
      free_count_ff <= opened_count_ff, "more freed rooms than rooms opened")
   `RAFQ_ASSERT(a_fifo_ptrs, clock, reset,
      free_tail_ff == free_head_ff + free_count_ff[FIFO_AW-1:0],
      "free FIFO pointers disagree with its count")
   `RAFQ_ASSERT(a_no_room_zero, clock, reset,
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_room_ff == ROOM_NONE),
      "failed item reports a room")

endmodule

// ----- rtl/rafq_ram.sv -----
`timescale 1ns / 1ps
module rafq_ram #(
   parameter int Width = 9,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
